// ----- sv/bscu_pkg.sv -----
// Shared types, constants and helpers for the barometric compensation unit.
`default_nettype none
package bscu_pkg;

	localparam int RAW_W   = 24;
	localparam int COEFF_W = 16;
	localparam int DT_W    = 25;
	localparam int TEMP_W  = 20;
	localparam int READ_W  = 18;
	localparam int MA_W    = 48;
	localparam int MB_W    = 24;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int WIDE_W  = 42;
	localparam int VAL_W   = 32;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_SENS     = 3'd0;
	localparam logic [IDX_W-1:0] REG_OFF      = 3'd1;
	localparam logic [IDX_W-1:0] REG_TCS      = 3'd2;
	localparam logic [IDX_W-1:0] REG_TCO      = 3'd3;
	localparam logic [IDX_W-1:0] REG_TREF     = 3'd4;
	localparam logic [IDX_W-1:0] REG_TEMPSENS = 3'd5;
	localparam logic [IDX_W-1:0] REG_SO_ON    = 3'd6;

	localparam logic MODE_TEMP  = 1'b0;
	localparam logic MODE_PRESS = 1'b1;

	localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -20'sd1500;
	localparam logic signed [VAL_W-1:0]  READ_MIN  = -32'sd4000;
	localparam logic signed [VAL_W-1:0]  READ_MAX  = 32'sd120000;

	typedef struct packed {
		logic [COEFF_W-1:0] sens;
		logic [COEFF_W-1:0] off;
		logic [COEFF_W-1:0] tcs;
		logic [COEFF_W-1:0] tco;
		logic [COEFF_W-1:0] tref;
		logic [COEFF_W-1:0] tempsens;
		logic               so_on;
	} cfg_t;

	typedef struct packed {
		logic                   start;
		logic signed [MA_W-1:0] a;
		logic [MB_W-1:0]        b;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

	function automatic logic [MB_W-1:0] abs25(input logic signed [DT_W-1:0] v);
		logic signed [DT_W-1:0] n;
		n = -v;
		return v[DT_W-1] ? n[MB_W-1:0] : v[MB_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- sv/baro_sensor_compensation_unit.sv -----
// Each item holds the unit until its result is registered; the next item is taken after.
// Each item takes one to five products from the bit-serial multiplier.
// A finished result waits in the output register while the next item is accepted.
// Reset (arst_n low) loads the calibration defaults, dT 0 and temperature 20.00 C.
`default_nettype none
module baro_sensor_compensation_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [23:0] raw_value
	input  wire logic [0:0]  s_axis_tuser,  // [0] mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [17:0] reading, [23:18] zero
	output logic [1:0]       m_axis_tuser,  // [0] kind, [1] clipped
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import bscu_pkg::*;

	cfg_t              cfg_q;
	mul_req_t          mreq;
	mul_rsp_t          mrsp;
	logic [READ_W-1:0] reading;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sens     <= 16'd40127;
			cfg_q.off      <= 16'd36924;
			cfg_q.tcs      <= 16'd23317;
			cfg_q.tco      <= 16'd23282;
			cfg_q.tref     <= 16'd33464;
			cfg_q.tempsens <= 16'd28312;
			cfg_q.so_on    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENS:     cfg_q.sens     <= cfg_data;
				REG_OFF:      cfg_q.off      <= cfg_data;
				REG_TCS:      cfg_q.tcs      <= cfg_data;
				REG_TCO:      cfg_q.tco      <= cfg_data;
				REG_TREF:     cfg_q.tref     <= cfg_data;
				REG_TEMPSENS: cfg_q.tempsens <= cfg_data;
				REG_SO_ON:    cfg_q.so_on    <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	bscu_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_mode     (s_axis_tuser[0]),
		.in_raw      (s_axis_tdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (m_axis_tuser[0]),
		.out_reading (reading),
		.out_clipped (m_axis_tuser[1]),
		.mreq        (mreq),
		.mrsp        (mrsp)
	);

	bscu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	assign m_axis_tdata = {6'd0, reading};

endmodule
`default_nettype wire

// ----- sv/bscu_mul.sv -----
// Bit-serial shift-and-add multiplier: signed multiplicand, unsigned multiplier.
`default_nettype none
module bscu_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bscu_pkg::mul_req_t req,
	output bscu_pkg::mul_rsp_t     rsp
);
	import bscu_pkg::*;

	logic signed [MA_W:0]   hi_q;
	logic [MB_W-1:0]        lo_q;
	logic [MB_W-1:0]        b_q;
	logic signed [MA_W-1:0] a_q;
	logic [4:0]             cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic signed [MA_W+1:0] sum;

	// One multiplier bit per cycle; the low product bits leave through lo_q.
	assign sum = {hi_q[MA_W], hi_q} + (b_q[0] ? {{2{a_q[MA_W-1]}}, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q <= '0;
			lo_q <= '0;
			a_q  <= req.a;
			b_q  <= req.b;
		end else if (busy_q) begin
			hi_q <= sum[MA_W+1:1];
			lo_q <= {sum[0], lo_q[MB_W-1:1]};
			b_q  <= {1'b0, b_q[MB_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = $signed({hi_q[MA_W-1:0], lo_q});

endmodule
`default_nettype wire

// ----- sv/bscu_seq.sv -----
// Compensation sequencer: kept temperature state, working registers and result stage.
`default_nettype none
module bscu_seq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire bscu_pkg::cfg_t               cfg,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         in_mode,
	input  wire logic [bscu_pkg::RAW_W-1:0]   in_raw,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              out_kind,
	output logic [bscu_pkg::READ_W-1:0]       out_reading,
	output logic                              out_clipped,
	output bscu_pkg::mul_req_t                mreq,
	input  wire bscu_pkg::mul_rsp_t           mrsp
);
	import bscu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_T_MUL1, ST_T_MUL2, ST_P_TCO, ST_P_TCS,
		ST_P_SQ, ST_P_SQ2, ST_P_MUL, ST_EMIT
	} state_t;

	state_t                   state_q;
	logic [RAW_W-1:0]         raw_q;
	logic                     mode_q;
	logic signed [DT_W-1:0]   dt_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic signed [WIDE_W-1:0] off_q;
	logic signed [WIDE_W-1:0] sens_q;
	logic signed [VAL_W-1:0]  val_q;
	mul_req_t                 mreq_q;
	logic                     out_valid_q;
	logic                     out_kind_q;
	logic [READ_W-1:0]        out_reading_q;
	logic                     out_clipped_q;

	logic signed [DT_W:0]     dt_n;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] p_sh7, p_sh8, p_sh21, p_sh23, p_sh31;
	logic signed [TEMP_W-1:0] temp_n;
	logic signed [DT_W-1:0]   ta, tb;
	logic signed [WIDE_W-1:0] sq, off_n, sens_n, sq5, sq7, sq11;
	logic signed [WIDE_W:0]   pdiff;
	logic signed [VAL_W-1:0]  clamp_v;
	logic                     clamp_c;
	logic                     low_on;

	always_comb begin
		prod   = mrsp.prod;
		dt_n   = $signed({2'b00, in_raw}) - $signed({2'b00, cfg.tref, 8'h00});
		p_sh7  = prod >>> 7;
		p_sh8  = prod >>> 8;
		p_sh21 = prod >>> 21;
		p_sh23 = prod >>> 23;
		p_sh31 = prod >>> 31;
		temp_n = TEMP_REF + $signed(p_sh23[TEMP_W-1:0]);
		low_on = cfg.so_on && (temp_q < TEMP_REF);
		ta     = DT_W'(temp_q) - DT_W'(TEMP_REF);
		tb     = DT_W'(temp_q) - DT_W'(TEMP_LOW);
		sq     = $signed(prod[WIDE_W-1:0]);
		sq5    = (sq <<< 2) + sq;
		sq7    = (sq <<< 3) - sq;
		sq11   = (sq <<< 3) + (sq <<< 1) + sq;
		off_n  = $signed({10'd0, cfg.off, 16'h0000}) + $signed(p_sh7[WIDE_W-1:0]);
		sens_n = $signed({11'd0, cfg.sens, 15'h0000}) + $signed(p_sh8[WIDE_W-1:0]);
		pdiff  = $signed(p_sh21[WIDE_W:0]) - {off_q[WIDE_W-1], off_q};
		if (val_q < READ_MIN) begin
			clamp_v = READ_MIN;
			clamp_c = 1'b1;
		end else if (val_q > READ_MAX) begin
			clamp_v = READ_MAX;
			clamp_c = 1'b1;
		end else begin
			clamp_v = val_q;
			clamp_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			raw_q         <= '0;
			mode_q        <= 1'b0;
			dt_q          <= '0;
			temp_q        <= TEMP_REF;
			off_q         <= '0;
			sens_q        <= '0;
			val_q         <= '0;
			mreq_q.start  <= 1'b0;
			mreq_q.a      <= '0;
			mreq_q.b      <= '0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= 1'b0;
			out_reading_q <= '0;
			out_clipped_q <= 1'b0;
		end else begin
			mreq_q.start <= 1'b0;
			if (out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						raw_q  <= in_raw;
						mode_q <= in_mode;
						mreq_q.start <= 1'b1;
						if (in_mode == MODE_TEMP) begin
							dt_q     <= dt_n[DT_W-1:0];
							mreq_q.a <= MA_W'(dt_n);
							mreq_q.b <= MB_W'(cfg.tempsens);
							state_q  <= ST_T_MUL1;
						end else begin
							mreq_q.a <= MA_W'(dt_q);
							mreq_q.b <= MB_W'(cfg.tco);
							state_q  <= ST_P_TCO;
						end
					end
				end
				ST_T_MUL1: begin
					if (mrsp.done) begin
						temp_q <= temp_n;
						if (cfg.so_on && temp_n < TEMP_REF) begin
							mreq_q.start <= 1'b1;
							mreq_q.a     <= MA_W'(abs25(dt_q));
							mreq_q.b     <= abs25(dt_q);
							state_q      <= ST_T_MUL2;
						end else begin
							val_q   <= VAL_W'(temp_n);
							state_q <= ST_EMIT;
						end
					end
				end
				ST_T_MUL2: begin
					if (mrsp.done) begin
						val_q   <= VAL_W'(temp_q) - $signed(p_sh31[VAL_W-1:0]);
						state_q <= ST_EMIT;
					end
				end
				ST_P_TCO: begin
					if (mrsp.done) begin
						off_q        <= off_n;
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MA_W'(dt_q);
						mreq_q.b     <= MB_W'(cfg.tcs);
						state_q      <= ST_P_TCS;
					end
				end
				ST_P_TCS: begin
					if (mrsp.done) begin
						sens_q       <= sens_n;
						mreq_q.start <= 1'b1;
						if (low_on) begin
							// Squares are formed from magnitudes so that they come out positive.
							mreq_q.a <= MA_W'(abs25(ta));
							mreq_q.b <= abs25(ta);
							state_q  <= ST_P_SQ;
						end else begin
							mreq_q.a <= MA_W'(sens_n);
							mreq_q.b <= raw_q;
							state_q  <= ST_P_MUL;
						end
					end
				end
				ST_P_SQ: begin
					if (mrsp.done) begin
						off_q        <= off_q - (sq5 >>> 1);
						sens_q       <= sens_q - (sq5 >>> 2);
						mreq_q.start <= 1'b1;
						if (temp_q < TEMP_LOW) begin
							mreq_q.a <= MA_W'(abs25(tb));
							mreq_q.b <= abs25(tb);
							state_q  <= ST_P_SQ2;
						end else begin
							mreq_q.a <= MA_W'(sens_q - (sq5 >>> 2));
							mreq_q.b <= raw_q;
							state_q  <= ST_P_MUL;
						end
					end
				end
				ST_P_SQ2: begin
					if (mrsp.done) begin
						off_q        <= off_q - sq7;
						sens_q       <= sens_q - (sq11 >>> 1);
						mreq_q.start <= 1'b1;
						mreq_q.a     <= MA_W'(sens_q - (sq11 >>> 1));
						mreq_q.b     <= raw_q;
						state_q      <= ST_P_MUL;
					end
				end
				ST_P_MUL: begin
					if (mrsp.done) begin
						val_q   <= VAL_W'(pdiff >>> 15);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					// The result register may still hold an earlier result.
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_kind_q    <= mode_q;
						out_reading_q <= clamp_v[READ_W-1:0];
						out_clipped_q <= clamp_c;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign mreq        = mreq_q;
	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_reading = out_reading_q;
	assign out_clipped = out_clipped_q;

endmodule
`default_nettype wire

// ----- sv/bscu_checker.sv -----
// Port-level checks for the compensation unit, bound to the top level.
`default_nettype none
module bscu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn before transfer");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in work");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[17:0]) >= -18'sd4000 &&
			$signed(m_axis_tdata[17:0]) <= 18'sd120000 && m_axis_tdata[23:18] == 6'd0))
		else $error("reading outside its range");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			(m_axis_tdata[17:0] == 18'h3F060 || m_axis_tdata[17:0] == 18'h1D4C0))
		else $error("clipped reading not at a limit");

endmodule

bind baro_sensor_compensation_unit bscu_checker u_bscu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- bench/tb_baro_sensor_compensation_unit.sv -----
// Self-checking bench for the barometric compensation unit: directed and random transfers.
`default_nettype none
module tb_baro_sensor_compensation_unit;
	import bscu_pkg::*;

	typedef struct packed {
		logic        mode;
		logic [23:0] raw;
	} conv_t;

	typedef struct packed {
		logic               kind;
		logic signed [17:0] reading;
		logic               clipped;
	} comp_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	baro_sensor_compensation_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Calibration words and the compensation state kept by the predictor.
	logic [15:0]        c_sens, c_off, c_tcs, c_tco, c_tref, c_tsens;
	logic               c_so;
	logic signed [24:0] kept_dt = '0;
	logic signed [19:0] kept_temp = 20'sd2000;

	conv_t  pending_conv[$];
	comp_t  expected_comp[$];
	int     mismatches;
	int     cycles;
	int     send_gap;
	int     recv_gap;
	bit     hold_sender;

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic comp_t saturate(logic kind, longint v);
		comp_t r;
		r.kind = kind;
		r.clipped = 1'b0;
		if (v < -4000) begin
			v = -4000; r.clipped = 1'b1;
		end
		if (v > 120000) begin
			v = 120000; r.clipped = 1'b1;
		end
		r.reading = v[17:0];
		return r;
	endfunction

	// >>> on longint is an arithmetic shift, so it floors as the datasheet integer code does.
	function automatic comp_t compensate(conv_t c);
		longint dt, temp, off, sens, a, sq, off2, sens2, b, sq2, p, raw;
		raw = longint'(c.raw);
		if (c.mode == MODE_TEMP) begin
			dt = raw - longint'(c_tref) * 256;
			temp = 2000 + ((dt * longint'(c_tsens)) >>> 23);
			kept_dt = dt[24:0];
			kept_temp = temp[19:0];
			if (c_so && temp < 2000)
				temp = temp - ((dt * dt) >>> 31);
			return saturate(MODE_TEMP, temp);
		end
		dt = longint'(kept_dt);
		temp = longint'(kept_temp);
		off = longint'(c_off) * 65536 + ((longint'(c_tco) * dt) >>> 7);
		sens = longint'(c_sens) * 32768 + ((longint'(c_tcs) * dt) >>> 8);
		if (c_so && temp < 2000) begin
			a = temp - 2000;
			sq = a * a;
			off2 = (5 * sq) >>> 1;
			sens2 = (5 * sq) >>> 2;
			if (temp < -1500) begin
				b = temp + 1500;
				sq2 = b * b;
				off2 += 7 * sq2;
				sens2 += (11 * sq2) >>> 1;
			end
			off -= off2;
			sens -= sens2;
		end
		p = (((raw * sens) >>> 21) - off) >>> 15;
		return saturate(MODE_PRESS, p);
	endfunction

	// Driver: one transfer per queued conversion, with a random gap before each.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			send_gap <= 0;
		end else if (s_axis_tvalid && !s_axis_tready) begin
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_conv.size() > 0 && !hold_sender) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= pending_conv[0].raw;
			s_axis_tuser <= pending_conv[0].mode;
			expected_comp.push_back(compensate(pending_conv[0]));
			void'(pending_conv.pop_front());
			send_gap <= (s_axis_tvalid || $urandom_range(0, 3) == 0) ? 0
				: int'($urandom_range(0, 4));
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Monitor: checks each result transfer against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		comp_t want;
		comp_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser[0];
				got.clipped = m_axis_tuser[1];
				got.reading = m_axis_tdata[17:0];
				if (expected_comp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result kind=%0d reading=%0d clipped=%0d",
							got.kind, got.reading, got.clipped);
				end else begin
					want = expected_comp.pop_front();
					if (got !== want || m_axis_tdata[23:18] !== 6'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected kind=%0d reading=%0d clipped=%0d,",
								" got kind=%0d reading=%0d clipped=%0d"},
								want.kind, want.reading, want.clipped,
								got.kind, got.reading, got.clipped);
					end
				end
				recv_gap <= int'($urandom_range(0, 4));
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 600000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SENS:     c_sens = value;
			REG_OFF:      c_off = value;
			REG_TCS:      c_tcs = value;
			REG_TCO:      c_tco = value;
			REG_TREF:     c_tref = value;
			REG_TEMPSENS: c_tsens = value;
			REG_SO_ON:    c_so = value[0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_conv.size() > 0 || s_axis_tvalid || expected_comp.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic queue_conv(logic mode, logic [23:0] raw);
		conv_t c;
		c.mode = mode;
		c.raw = raw;
		pending_conv.push_back(c);
	endtask

	// A temperature near a chosen centidegree value, followed by a few pressures.
	task automatic queue_session(int n);
		int target_c;
		longint raw;
		for (int i = 0; i < n; i++) begin
			target_c = $urandom_range(0, 3) == 0
				? int'($urandom_range(0, 16777215) % 12000) - 4000
				: int'($urandom_range(0, 8000)) - 4000;
			if (c_tsens != 0)
				raw = longint'(c_tref) * 256
					+ ((longint'(target_c - 2000) <<< 23) / longint'(c_tsens));
			else
				raw = longint'($urandom_range(0, 16777215));
			if (raw < 0 || raw > 16777215 || $urandom_range(0, 9) == 0)
				raw = longint'($urandom_range(0, 16777215));
			queue_conv(MODE_TEMP, raw[23:0]);
			repeat ($urandom_range(1, 4))
				queue_conv(MODE_PRESS, $urandom_range(0, 3) == 0
					? 24'($urandom_range(0, 16777215))
					: 24'($urandom_range(6000000, 10000000)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_sender = 1'b0;
		c_sens = 16'd40127; c_off = 16'd36924; c_tcs = 16'd23317; c_tco = 16'd23282;
		c_tref = 16'd33464; c_tsens = 16'd28312; c_so = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pressure before any temperature uses the reset state.
		queue_conv(MODE_PRESS, 24'd9085466);
		queue_conv(MODE_TEMP, 24'd8569150);
		queue_conv(MODE_PRESS, 24'd9085466);
		queue_conv(MODE_TEMP, 24'd0);
		queue_conv(MODE_PRESS, 24'd0);
		queue_conv(MODE_PRESS, 24'hFFFFFF);
		queue_conv(MODE_TEMP, 24'hFFFFFF);
		queue_conv(MODE_PRESS, 24'hFFFFFF);
		queue_conv(MODE_PRESS, 24'hAAAAAA);
		queue_conv(MODE_PRESS, 24'h555555);
		wait_idle();

		// Second-order correction, including the very cold branch.
		write_reg(REG_SO_ON, 16'd1);
		queue_conv(MODE_TEMP, 24'd7000000);
		queue_conv(MODE_PRESS, 24'd9085466);
		queue_conv(MODE_TEMP, 24'd4000000);
		queue_conv(MODE_PRESS, 24'd9085466);
		queue_conv(MODE_TEMP, 24'd8569150);
		queue_conv(MODE_PRESS, 24'd9085466);
		queue_conv(MODE_TEMP, 24'd0);
		queue_conv(MODE_PRESS, 24'hFFFFFF);
		queue_session(40);
		// Part way through, the sender waits until every result so far has come back.
		while (pending_conv.size() > 60)
			@(posedge clk);
		hold_sender = 1'b1;
		while (s_axis_tvalid || expected_comp.size() > 0)
			@(posedge clk);
		hold_sender = 1'b0;
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			for (int r = 0; r <= 5; r++)
				case (phase)
					0: write_reg(r[2:0], 16'hFFFF);
					1: write_reg(r[2:0], 16'h0000);
					default: write_reg(r[2:0], 16'($urandom_range(16384, 65535)));
				endcase
			if (phase >= 2) begin
				write_reg(REG_TREF, 16'($urandom_range(20000, 45000)));
				write_reg(REG_TEMPSENS, 16'($urandom_range(20000, 40000)));
			end
			write_reg(REG_SO_ON, {15'd0, phase[0]});
			queue_session(phase < 2 ? 10 : 25);
			for (int k = 0; k < 10; k++)
				queue_conv(1'($urandom_range(0, 1)), 24'($urandom_range(0, 16777215)));
			wait_idle();
		end

		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_comp.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/bscu_pkg.sv
sv/bscu_mul.sv
sv/bscu_seq.sv
sv/baro_sensor_compensation_unit.sv
sv/bscu_checker.sv
bench/tb_baro_sensor_compensation_unit.sv
